FILE: src/modbus_request_framer_assert.svh
// Assertion macros shared by the framer modules.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef MODBUS_REQUEST_FRAMER_ASSERT_SVH
`define MODBUS_REQUEST_FRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mrf_pkg.sv
// Types, constants and the CRC-16 byte fold for the Modbus RTU request framer.
// No dependencies; every other file but the assertion header uses this package by scoped names.
package mrf_pkg;

   localparam logic [2:0] OP_READ_INPUT   = 3'd0;
   localparam logic [2:0] OP_READ_HOLDING = 3'd1;
   localparam logic [2:0] OP_WRITE_HEADER = 3'd2;
   localparam logic [2:0] OP_DATA_WORD    = 3'd3;

   localparam logic [7:0] FN_READ_INPUT   = 8'h04;
   localparam logic [7:0] FN_READ_HOLDING = 8'h03;
   localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

   localparam logic [6:0] READ_MAX_WORDS  = 7'd125;
   localparam logic [6:0] WRITE_MAX_WORDS = 7'd123;

   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  unit;
      logic [15:0] reg_address;
      logic [6:0]  word_count;
      logic [15:0] data_word;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last;
      logic       error;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_ERROR,
      KIND_READ,
      KIND_WRITE_HEADER,
      KIND_DATA
   } kind_type;

   // One classified command. For a data word, word holds the data value;
   // for a header it holds the register address.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  unit;
      logic [7:0]  func;
      logic [15:0] word;
      logic [6:0]  count;
      logic        tail;
   } cmd_type;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

FILE: src/modbus_request_framer.sv
// Modbus RTU request framer: requests in, frame bytes with trailing CRC-16 out.
// Path: the first byte of a request passes through the command queue and then the result
// buffer before it reaches the result ports.
// Throughput: one frame byte per cycle while the result buffer has room; a read frame is 8
// bytes, a write header 7 (9 with zero count), a data word 2 (4 with the closing CRC), an error 1.
// Reset: synchronous; empties both queues, closes any pending write and reseeds the CRC.
module modbus_request_framer #(
   parameter int CMD_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  mrf_pkg::req_type   req_item,
   output logic               empty,
   input  logic               pop,
   output mrf_pkg::rsp_type   rsp_item
);

   logic             accept, cmd_push, cmd_pop, cmd_empty;
   mrf_pkg::cmd_type cmd_in, cmd_out;

   assign accept = push && !full;

   mrf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .cmd_push (cmd_push),
      .cmd_item (cmd_in)
   );

   mrf_cmd_queue #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_in),
      .rd_en   (cmd_pop),
      .rd_data (cmd_out),
      .full    (full),
      .empty   (cmd_empty)
   );

   mrf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_item  (cmd_out),
      .cmd_pop   (cmd_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: src/mrf_front.sv
// Front end: accepts request beats, tracks the open write and classifies each beat.
// Depends on mrf_pkg.
module mrf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  mrf_pkg::req_type   req_item,
   output logic               cmd_push,
   output mrf_pkg::cmd_type   cmd_item
);

   logic [6:0] words_left_ff, words_left_in;

   always_comb begin
      words_left_in  = words_left_ff;
      cmd_item.kind  = mrf_pkg::KIND_ERROR;
      cmd_item.unit  = req_item.unit;
      cmd_item.func  = mrf_pkg::FN_WRITE_MULTI;
      cmd_item.word  = req_item.reg_address;
      cmd_item.count = req_item.word_count;
      cmd_item.tail  = 1'b0;
      unique case (req_item.op)
         mrf_pkg::OP_READ_INPUT, mrf_pkg::OP_READ_HOLDING: begin
            words_left_in = '0;
            cmd_item.func = (req_item.op == mrf_pkg::OP_READ_INPUT) ?
                            mrf_pkg::FN_READ_INPUT : mrf_pkg::FN_READ_HOLDING;
            if (req_item.word_count <= mrf_pkg::READ_MAX_WORDS) begin
               cmd_item.kind = mrf_pkg::KIND_READ;
               cmd_item.tail = 1'b1;
            end
         end
         mrf_pkg::OP_WRITE_HEADER: begin
            words_left_in = '0;
            if (req_item.word_count <= mrf_pkg::WRITE_MAX_WORDS) begin
               cmd_item.kind = mrf_pkg::KIND_WRITE_HEADER;
               cmd_item.tail = (req_item.word_count == '0);
               words_left_in = req_item.word_count;
            end
         end
         mrf_pkg::OP_DATA_WORD: begin
            // A stray word leaves the pending write state alone.
            if (words_left_ff != '0) begin
               cmd_item.kind = mrf_pkg::KIND_DATA;
               cmd_item.word = req_item.data_word;
               cmd_item.tail = (words_left_ff == 7'd1);
               words_left_in = words_left_ff - 7'd1;
            end
         end
         default: begin
            words_left_in = '0;
         end
      endcase
   end

   assign cmd_push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         words_left_ff <= '0;
      end else if (accept) begin
         words_left_ff <= words_left_in;
      end
   end

endmodule

FILE: src/mrf_cmd_queue.sv
// Short command queue between the front end and the byte sequencer.
// Depends on mrf_pkg; DEPTH must be at least 2.
module mrf_cmd_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  mrf_pkg::cmd_type   wr_data,
   input  logic               rd_en,
   output mrf_pkg::cmd_type   rd_data,
   output logic               full,
   output logic               empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   mrf_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: src/mrf_back.sv
// Back end: walks each command byte by byte, keeps the running CRC-16 and
// feeds a two-entry result buffer. Depends on mrf_pkg and the assertion header.
`include "modbus_request_framer_assert.svh"

module mrf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_empty,
   input  mrf_pkg::cmd_type   cmd_item,
   output logic               cmd_pop,
   input  logic               pop,
   output logic               empty,
   output mrf_pkg::rsp_type   rsp_item
);

   logic [3:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;

   mrf_pkg::rsp_type out_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   logic [3:0]  payload_len, total_len;
   logic        has_tail, fold, tail_lo, tail_hi, done, step, do_pop;
   logic [15:0] crc_base;
   mrf_pkg::rsp_type beat;

   always_comb begin
      payload_len = 4'd1;
      has_tail    = 1'b0;
      unique case (cmd_item.kind)
         mrf_pkg::KIND_READ: begin
            payload_len = 4'd6;
            has_tail    = 1'b1;
         end
         mrf_pkg::KIND_WRITE_HEADER: begin
            payload_len = 4'd7;
            has_tail    = cmd_item.tail;
         end
         mrf_pkg::KIND_DATA: begin
            payload_len = 4'd2;
            has_tail    = cmd_item.tail;
         end
         default: begin
            payload_len = 4'd1;
            has_tail    = 1'b0;
         end
      endcase
      total_len = payload_len + (has_tail ? 4'd2 : 4'd0);
   end

   assign tail_lo = has_tail && (idx_ff == payload_len);
   assign tail_hi = has_tail && (idx_ff == payload_len + 4'd1);
   assign fold    = (cmd_item.kind != mrf_pkg::KIND_ERROR) && (idx_ff < payload_len);
   assign done    = (idx_ff == total_len - 4'd1);
   assign step    = !cmd_empty && (count_ff != 2'd2);
   assign cmd_pop = step && done;

   // Each read or write header starts a fresh frame, so its first byte folds into the seed.
   assign crc_base = ((idx_ff == '0) && (cmd_item.kind == mrf_pkg::KIND_READ ||
                      cmd_item.kind == mrf_pkg::KIND_WRITE_HEADER)) ?
                     mrf_pkg::CRC_SEED : crc_ff;

   always_comb begin
      beat.frame_byte = 8'h00;
      beat.last       = 1'b0;
      beat.error      = 1'b0;
      if (cmd_item.kind == mrf_pkg::KIND_ERROR) begin
         beat.last  = 1'b1;
         beat.error = 1'b1;
      end else if (tail_lo) begin
         beat.frame_byte = crc_ff[7:0];
      end else if (tail_hi) begin
         beat.frame_byte = crc_ff[15:8];
         beat.last       = 1'b1;
      end else if (cmd_item.kind == mrf_pkg::KIND_DATA) begin
         beat.frame_byte = idx_ff[0] ? cmd_item.word[7:0] : cmd_item.word[15:8];
      end else begin
         unique case (idx_ff)
            4'd0:    beat.frame_byte = cmd_item.unit;
            4'd1:    beat.frame_byte = cmd_item.func;
            4'd2:    beat.frame_byte = cmd_item.word[15:8];
            4'd3:    beat.frame_byte = cmd_item.word[7:0];
            4'd5:    beat.frame_byte = {1'b0, cmd_item.count};
            4'd6:    beat.frame_byte = {cmd_item.count, 1'b0};
            default: beat.frame_byte = 8'h00;
         endcase
      end
   end

   always_comb begin
      crc_in = crc_ff;
      idx_in = idx_ff;
      if (step) begin
         idx_in = done ? '0 : idx_ff + 4'd1;
         if (fold) begin
            crc_in = mrf_pkg::crc_fold(crc_base, beat.frame_byte);
         end else if (tail_hi) begin
            crc_in = mrf_pkg::CRC_SEED;
         end
      end
   end

   assign empty    = (count_ff == 2'd0);
   assign do_pop   = pop && !empty;
   assign rsp_item = out_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff[wr_ptr_ff] <= beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         crc_ff    <= mrf_pkg::CRC_SEED;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         crc_ff <= crc_in;
         if (step) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (step && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !step) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   `MRF_ASSERT_SAME(a_buffer_bound, clock, reset, 1'b1, count_ff != 2'd3, "result buffer overflow")
   `MRF_ASSERT_SAME(a_index_in_frame, clock, reset, !cmd_empty, idx_ff < total_len, "byte index past command")
   `MRF_ASSERT_NEXT(a_crc_reseed, clock, reset, step && tail_hi, crc_ff == mrf_pkg::CRC_SEED, "CRC not reseeded after frame")
   `MRF_ASSERT_SAME(a_error_is_last, clock, reset, !empty && rsp_item.error, rsp_item.last, "error beat without last")

endmodule
